// ===== hdl/cmoa_pkg.sv =====
// Shared types, constants, calendar helpers and microcode for the minute offset adder.
package cmoa_pkg;

  // Calendar range and fixed calendar constants
  localparam int FIRST_YEAR     = 1830;
  localparam int LAST_YEAR      = 2099;
  localparam int MIN_PER_DAY    = 60 * 24;
  localparam int ANCHOR_YEAR    = 1801;
  localparam int ANCHOR_WEEKDAY = 3;
  localparam int CENTURY_YEAR   = 1900;

  // Day number of 1 January, counted from year zero with the local leap rule
  localparam int DAYNUM_FIRST  = 365 * FIRST_YEAR + (FIRST_YEAR + 3) / 4
                                 - ((FIRST_YEAR > CENTURY_YEAR) ? 1 : 0);
  localparam int DAYNUM_ANCHOR = 365 * ANCHOR_YEAR + (ANCHOR_YEAR + 3) / 4
                                 - ((ANCHOR_YEAR > CENTURY_YEAR) ? 1 : 0);
  // Weekday phase (0 = Monday) of the first day of FIRST_YEAR
  localparam int WD_START      = (DAYNUM_FIRST - DAYNUM_ANCHOR + ANCHOR_WEEKDAY) % 7;

  localparam int YEAR_MIN      = 365 * MIN_PER_DAY;
  localparam int LEAP_YEAR_MIN = 366 * MIN_PER_DAY;

  // Payload of one input beat
  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic [4:0]         hour_in;
    logic [5:0]         minute_in;
    logic signed [15:0] offset;
  } item_t;

  // Payload of one result beat
  typedef struct packed {
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [27:0] serial_minutes;
    logic [2:0]  weekday;
    logic        out_of_range;
  } result_t;

  // Offset unit codes
  localparam logic [1:0] FUNC_MINUTES = 2'd0;
  localparam logic [1:0] FUNC_HOURS   = 2'd1;
  localparam logic [1:0] FUNC_DAYS    = 2'd2;

  // Datapath operations
  localparam logic [3:0] OP_IDLE  = 4'd0;   // wait for an item, latch it
  localparam logic [3:0] OP_DAYS  = 4'd1;   // days from FIRST_YEAR to start year
  localparam logic [3:0] OP_MDAY  = 4'd2;   // add month and day of month
  localparam logic [3:0] OP_TOMIN = 4'd3;   // days to minutes, add hour and minute
  localparam logic [3:0] OP_OFFS  = 4'd4;   // add scaled offset
  localparam logic [3:0] OP_INIT  = 4'd5;   // prime the decode walk
  localparam logic [3:0] OP_YWALK = 4'd6;   // strip whole years
  localparam logic [3:0] OP_MWALK = 4'd7;   // strip whole months
  localparam logic [3:0] OP_DWALK = 4'd8;   // strip whole days
  localparam logic [3:0] OP_HWALK = 4'd9;   // strip whole hours
  localparam logic [3:0] OP_DONE  = 4'd10;  // load result register
  localparam logic [3:0] OP_OOR   = 4'd11;  // load out-of-range result

  // Sequencing conditions
  localparam logic [2:0] COND_NEXT   = 3'd0;  // always advance
  localparam logic [2:0] COND_ACCEPT = 3'd1;  // hold until an item is taken
  localparam logic [2:0] COND_NEG    = 3'd2;  // jump if the sum is negative
  localparam logic [2:0] COND_LOOP   = 3'd3;  // repeat while the walk continues
  localparam logic [2:0] COND_YEAR   = 3'd4;  // as loop, jump on passing LAST_YEAR
  localparam logic [2:0] COND_OUT    = 3'd5;  // hold until result register free, jump

  // Microcode addresses
  localparam logic [3:0] ADDR_IDLE = 4'd0;
  localparam logic [3:0] ADDR_OOR  = 4'd11;

  // One control word
  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cond;
    logic [3:0] target;
  } ctrl_t;

  // Status returned by the datapath
  typedef struct packed {
    logic in_take;
    logic neg;
    logic more;
    logic ovf;
    logic out_free;
  } status_t;

  // Microprogram
  function automatic ctrl_t ucode(input logic [3:0] addr);
    ctrl_t w;
    case (addr)
      4'd0:    w = '{op: OP_IDLE,  cond: COND_ACCEPT, target: ADDR_IDLE};
      4'd1:    w = '{op: OP_DAYS,  cond: COND_NEXT,   target: ADDR_IDLE};
      4'd2:    w = '{op: OP_MDAY,  cond: COND_NEXT,   target: ADDR_IDLE};
      4'd3:    w = '{op: OP_TOMIN, cond: COND_NEXT,   target: ADDR_IDLE};
      4'd4:    w = '{op: OP_OFFS,  cond: COND_NEXT,   target: ADDR_IDLE};
      4'd5:    w = '{op: OP_INIT,  cond: COND_NEG,    target: ADDR_OOR};
      4'd6:    w = '{op: OP_YWALK, cond: COND_YEAR,   target: ADDR_OOR};
      4'd7:    w = '{op: OP_MWALK, cond: COND_LOOP,   target: ADDR_IDLE};
      4'd8:    w = '{op: OP_DWALK, cond: COND_LOOP,   target: ADDR_IDLE};
      4'd9:    w = '{op: OP_HWALK, cond: COND_LOOP,   target: ADDR_IDLE};
      4'd10:   w = '{op: OP_DONE,  cond: COND_OUT,    target: ADDR_IDLE};
      4'd11:   w = '{op: OP_OOR,   cond: COND_OUT,    target: ADDR_IDLE};
      default: w = '{op: OP_IDLE,  cond: COND_OUT,    target: ADDR_IDLE};
    endcase
    return w;
  endfunction

  // Leap rule: divisible by four, 1900 excepted
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'd0) && (y != 12'(CENTURY_YEAR));
  endfunction

  // Days before the first of a month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of a month in days
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:                  d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:               d = 5'd31;
    endcase
    return d;
  endfunction

  // Weekday phase step, modulo seven
  function automatic logic [2:0] wd_add(input logic [2:0] w, input logic [1:0] k);
    logic [3:0] s;
    s = {1'b0, w} + {2'b00, k};
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

endpackage

// ===== hdl/cmoa_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
module cmoa_seq
  import cmoa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [3:0] step;
  logic [3:0] step_next;

  assign ctrl = ucode(step);

  // Next step from the condition field
  always_comb begin
    case (ctrl.cond)
      COND_NEXT:   step_next = step + 4'd1;
      COND_ACCEPT: step_next = status.in_take ? step + 4'd1 : step;
      COND_NEG:    step_next = status.neg ? ctrl.target : step + 4'd1;
      COND_LOOP:   step_next = status.more ? step : step + 4'd1;
      COND_YEAR:   step_next = status.ovf ? ctrl.target :
                               (status.more ? step : step + 4'd1);
      COND_OUT:    step_next = status.out_free ? ctrl.target : step;
      default:     step_next = ADDR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ADDR_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hdl/cmoa_dp.sv =====
// Datapath: item latch, minute accumulator, decode walk registers and result register.
module cmoa_dp
  import cmoa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  ctrl_t   ctrl,
  output status_t status,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  item_t              q;
  logic signed [22:0] dacc;
  logic [31:0]        acc;
  logic [30:0]        rem;
  logic [11:0]        y;
  logic [3:0]         m;
  logic [4:0]         dcnt;
  logic [4:0]         hcnt;
  logic [2:0]         wd;

  logic [3:0]  mo_clamp;
  item_t       item_fix;
  logic [21:0] dnum;
  logic [10:0] scale;
  logic        y_leap;
  logic [19:0] ylen;
  logic [4:0]  mlen;
  logic [15:0] mlen_min;
  logic        y_take;
  logic        m_take;
  logic        d_take;
  logic        h_take;
  logic        walk_more;
  logic        walk_ovf;

  // Handshake and status
  assign item_stall = (ctrl.op != OP_IDLE);
  assign status     = '{in_take:  item_valid && !item_stall,
                        neg:      acc[31],
                        more:     walk_more,
                        ovf:      walk_ovf,
                        out_free: !result_valid || !result_stall};

  // Start-date arithmetic
  always_comb begin
    if (item.month_in == 4'd0) begin
      mo_clamp = 4'd1;
    end else if (item.month_in > 4'd12) begin
      mo_clamp = 4'd12;
    end else begin
      mo_clamp = item.month_in;
    end
    item_fix          = item;
    item_fix.month_in = mo_clamp;
    dnum = 22'(q.year_in) * 22'd365 + 22'((13'(q.year_in) + 13'd3) >> 2)
           - 22'(q.year_in > 12'(CENTURY_YEAR));
    case (q.func)
      FUNC_MINUTES: scale = 11'd1;
      FUNC_HOURS:   scale = 11'd60;
      FUNC_DAYS:    scale = 11'(MIN_PER_DAY);
      default:      scale = 11'd0;
    endcase
  end

  // Decode walk comparisons
  always_comb begin
    y_leap   = is_leap(y);
    ylen     = y_leap ? 20'(LEAP_YEAR_MIN) : 20'(YEAR_MIN);
    mlen     = month_days(m, y_leap);
    mlen_min = 16'(mlen) * 16'(MIN_PER_DAY);
    y_take   = (rem >= 31'(ylen));
    m_take   = (rem >= 31'(mlen_min)) && (m < 4'd12);
    d_take   = (rem >= 31'(MIN_PER_DAY));
    h_take   = (rem >= 31'd60);
    case (ctrl.op)
      OP_YWALK: begin
        walk_more = y_take && (y != 12'(LAST_YEAR));
        walk_ovf  = y_take && (y == 12'(LAST_YEAR));
      end
      OP_MWALK: begin
        walk_more = m_take;
        walk_ovf  = 1'b0;
      end
      OP_DWALK: begin
        walk_more = d_take;
        walk_ovf  = 1'b0;
      end
      OP_HWALK: begin
        walk_more = h_take;
        walk_ovf  = 1'b0;
      end
      default: begin
        walk_more = 1'b0;
        walk_ovf  = 1'b0;
      end
    endcase
  end

  // Working registers, one operation per step
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_IDLE: begin
        if (item_valid) begin
          q <= item_fix;
        end
      end
      OP_DAYS: begin
        dacc <= 23'({1'b0, dnum}) - 23'(DAYNUM_FIRST);
      end
      OP_MDAY: begin
        dacc <= dacc + 23'(month_start(q.month_in)) + 23'(q.day_in) - 23'd1
                + 23'((q.month_in > 4'd2) && is_leap(q.year_in));
      end
      OP_TOMIN: begin
        acc <= 32'(dacc) * 32'(MIN_PER_DAY) + 32'(q.hour_in) * 32'd60
               + 32'(q.minute_in);
      end
      OP_OFFS: begin
        acc <= acc + 32'(q.offset) * 32'(scale);
      end
      OP_INIT: begin
        rem  <= acc[30:0];
        y    <= 12'(FIRST_YEAR);
        m    <= 4'd1;
        dcnt <= 5'd1;
        hcnt <= 5'd0;
        wd   <= 3'(WD_START);
      end
      OP_YWALK: begin
        if (y_take) begin
          rem <= rem - 31'(ylen);
          y   <= y + 12'd1;
          wd  <= wd_add(wd, y_leap ? 2'd2 : 2'd1);
        end
      end
      OP_MWALK: begin
        if (m_take) begin
          rem <= rem - 31'(mlen_min);
          m   <= m + 4'd1;
          // month length less 28 is its weekday shift
          wd  <= wd_add(wd, 2'(mlen - 5'd28));
        end
      end
      OP_DWALK: begin
        if (d_take) begin
          rem  <= rem - 31'(MIN_PER_DAY);
          dcnt <= dcnt + 5'd1;
          wd   <= wd_add(wd, 2'd1);
        end
      end
      OP_HWALK: begin
        if (h_take) begin
          rem  <= rem - 31'd60;
          hcnt <= hcnt + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register; loads only when the previous beat has gone
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((ctrl.op == OP_DONE || ctrl.op == OP_OOR) && status.out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.out_free) begin
      if (ctrl.op == OP_DONE) begin
        result.year_out       <= y;
        result.month_out      <= m;
        result.day_out        <= dcnt;
        result.hour_out       <= hcnt;
        result.minute_out     <= rem[5:0];
        result.serial_minutes <= acc[27:0];
        result.weekday        <= wd + 3'd1;
        result.out_of_range   <= 1'b0;
      end else if (ctrl.op == OP_OOR) begin
        result <= '{out_of_range: 1'b1, default: '0};
      end
    end
  end

endmodule

// ===== hdl/calendar_minute_offset_adder_unit.sv =====
// Calendar minute offset adder: top level joining sequencer and datapath.
//
// Takes a start date-time, a signed offset and a unit (minutes, hours, days),
// forms the serial minute count from 1830-01-01 00:00, adds the offset and
// decodes the sum back into year, month, day, hour, minute and weekday
// (1 Monday .. 7 Sunday). Results before 1830 or after 2099 come back with
// out_of_range set and every other field zero. One item is in work at a time:
// the start date is turned into minutes and the offset added, then decode
// walks strip whole years, months, days and hours one at a time from the sum.
// A negative sum skips the walks. The walks are stepped by a microcode
// program, each walk with its own compare and subtract on the remainder.
// The result sits in an output register, so the next item is taken while the
// previous result still waits to be collected.
module calendar_minute_offset_adder_unit
  import cmoa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  ctrl_t   ctrl;
  status_t status;

  cmoa_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  cmoa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== hdl/cmoa_checker.sv =====
// Port-level checks on the minute offset adder, bound to the top level.
module cmoa_checker
  import cmoa_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled input beat holds
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("input beat changed while stalled");

  // A stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // One item at a time: busy straight after taking a beat
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input taken while previous item in work");

  // Out-of-range results carry no date
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_of_range |->
      result.year_out == 12'd0 && result.month_out == 4'd0 &&
      result.day_out == 5'd0 && result.weekday == 3'd0 &&
      result.serial_minutes == 28'd0)
    else $error("out-of-range result with non-zero fields");

  // In-range results are proper calendar values
  a_in_range_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_of_range |->
      result.year_out >= 12'(FIRST_YEAR) && result.year_out <= 12'(LAST_YEAR) &&
      result.month_out != 4'd0 && result.month_out <= 4'd12 &&
      result.day_out != 5'd0 && result.hour_out < 5'd24 &&
      result.minute_out < 6'd60 && result.weekday != 3'd0)
    else $error("in-range result outside calendar bounds");

endmodule

bind calendar_minute_offset_adder_unit cmoa_checker u_checker (.*);
